FILE: src/bxt_pkg.sv
package bxt_pkg;

  localparam int KEY_BITS   = 31;
  localparam int NODE_POOL  = 8192;
  localparam int COUNT_BITS = 16;

  // Derived widths
  localparam int NODE_AW = $clog2(NODE_POOL);
  localparam int NF_W    = $clog2(NODE_POOL + 1);
  localparam int LVL_W   = $clog2(KEY_BITS);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // One trie node: two child links, two branch counts
  typedef struct packed {
    logic [1:0][NODE_AW-1:0]    child;
    logic [1:0][COUNT_BITS-1:0] count;
  } node_t;

  localparam int NODE_W = $bits(node_t);

  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_DELETE = 2'd1,
    FUNC_QUERY  = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_POOL_FULL = 2'd1,
    STAT_EMPTY     = 2'd2,
    STAT_ABSENT    = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_CHECK,
    S_INS_UPD,
    S_DEL_CHECK,
    S_DEL_UPD,
    S_QUERY,
    S_DONE
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic    load;        // capture key, clear result, start walk at root
    logic    init;        // restart walk at root
    logic    check_step;  // follow key bit
    logic    query_step;  // follow opposite bit when populated
    logic    ins_step;    // insert update at current level
    logic    del_step;    // delete update at current level
    logic    set_status;
    status_e status;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic last;        // walk is at the lowest key bit
    logic count_full;  // branch count saturated
    logic go_off;      // branch has no child
    logic absent;      // branch missing or empty
    logic pool_fail;   // not enough free nodes for this insert
    logic root_empty;  // no keys stored
  } stat_t;

endpackage

FILE: src/bxt_ram.sv
module bxt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/bxt_datapath.sv
module bxt_datapath import bxt_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [KEY_BITS-1:0] key_value_i,
  input  cmd_t                cmd_i,
  output stat_t               stat_o,
  output logic [KEY_BITS-1:0] max_xor_o,
  output logic [1:0]          status_o
);

  localparam logic [NF_W:0] POOL_LIM = (NF_W+1)'(NODE_POOL);

  logic [KEY_BITS-1:0] key_q, key_d;
  logic [KEY_BITS-1:0] acc_q, acc_d;
  logic [NODE_AW-1:0]  cur_q, cur_d;
  logic [LVL_W-1:0]    level_q, level_d;
  logic                fresh_q, fresh_d;
  logic [NF_W-1:0]     nf_q, nf_d;
  node_t               root_q, root_d;
  status_e             status_q, status_d;

  node_t               ram_rdata;
  node_t               nd;
  node_t               wnode;
  logic                ram_we;
  logic                b;
  logic                o;
  logic [NODE_AW-1:0]  child_b;
  logic [NODE_AW-1:0]  child_o;
  logic [COUNT_BITS-1:0] cnt_b;
  logic [COUNT_BITS-1:0] cnt_o;
  logic                take_o;
  logic [NF_W:0]       missing;
  logic [NF_W:0]       need;

  // Node under the walk: root lives in flops, the rest in RAM
  assign nd      = (cur_q == '0) ? root_q : ram_rdata;
  assign b       = key_q[level_q];
  assign o       = ~b;
  assign child_b = nd.child[b];
  assign child_o = nd.child[o];
  assign cnt_b   = nd.count[b];
  assign cnt_o   = nd.count[o];
  assign take_o  = (child_o != '0) && (cnt_o != '0);

  // Pool check: every level from here down needs a new node once off the tree
  assign missing = stat_o.go_off ? ((NF_W+1)'(level_q) + (NF_W+1)'(1)) : '0;
  assign need    = {1'b0, nf_q} + missing;

  assign stat_o.last       = (level_q == '0);
  assign stat_o.count_full = (cnt_b == COUNT_MAX);
  assign stat_o.go_off     = (child_b == '0);
  assign stat_o.absent     = (child_b == '0) || (cnt_b == '0);
  assign stat_o.pool_fail  = (need > POOL_LIM);
  assign stat_o.root_empty = (root_q.count[0] == '0) && (root_q.count[1] == '0);

  // Walk, update and result logic
  always_comb begin
    key_d    = key_q;
    acc_d    = acc_q;
    cur_d    = cur_q;
    level_d  = level_q;
    fresh_d  = fresh_q;
    nf_d     = nf_q;
    root_d   = root_q;
    status_d = status_q;
    wnode    = nd;
    ram_we   = 1'b0;

    if (cmd_i.load) begin
      key_d    = key_value_i;
      acc_d    = '0;
      status_d = STAT_OK;
    end

    if (cmd_i.load || cmd_i.init) begin
      cur_d   = '0;
      level_d = LVL_W'(KEY_BITS - 1);
      fresh_d = 1'b0;
    end else if (cmd_i.check_step) begin
      cur_d   = child_b;
      level_d = level_q - 1'b1;
    end else if (cmd_i.query_step) begin
      cur_d          = take_o ? child_o : child_b;
      acc_d[level_q] = take_o;
      level_d        = level_q - 1'b1;
    end else if (cmd_i.ins_step) begin
      level_d = level_q - 1'b1;
      if (fresh_q) begin
        // freshly allocated node: its old contents are never used
        wnode          = '0;
        wnode.child[b] = nf_q[NODE_AW-1:0];
        wnode.count[b] = COUNT_BITS'(1);
      end else if (child_b == '0) begin
        wnode.child[b] = nf_q[NODE_AW-1:0];
        wnode.count[b] = cnt_b + 1'b1;
      end else begin
        wnode.count[b] = cnt_b + 1'b1;
      end
      if (fresh_q || (child_b == '0)) begin
        cur_d   = nf_q[NODE_AW-1:0];
        nf_d    = nf_q + 1'b1;
        fresh_d = 1'b1;
      end else begin
        cur_d = child_b;
      end
      if (cur_q == '0) begin
        root_d = wnode;
      end else begin
        ram_we = 1'b1;
      end
    end else if (cmd_i.del_step) begin
      level_d        = level_q - 1'b1;
      wnode.count[b] = cnt_b - 1'b1;
      cur_d          = child_b;
      if (cur_q == '0) begin
        root_d = wnode;
      end else begin
        ram_we = 1'b1;
      end
    end

    if (cmd_i.set_status) begin
      status_d = cmd_i.status;
    end
  end

  // Control and bookkeeping state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nf_q     <= NF_W'(1);
      root_q   <= '0;
      cur_q    <= '0;
      level_q  <= '0;
      fresh_q  <= 1'b0;
      status_q <= STAT_OK;
    end else begin
      nf_q     <= nf_d;
      root_q   <= root_d;
      cur_q    <= cur_d;
      level_q  <= level_d;
      fresh_q  <= fresh_d;
      status_q <= status_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    acc_q <= acc_d;
  end

  // Node store; read address follows the next walk position
  bxt_ram #(
    .WIDTH (NODE_W),
    .DEPTH (NODE_POOL)
  ) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cur_q),
    .wdata_i (wnode),
    .raddr_i (cur_d),
    .rdata_o (ram_rdata)
  );

  assign max_xor_o = acc_q;
  assign status_o  = status_q;

endmodule

FILE: src/bxt_ctrl.sv
module bxt_ctrl import bxt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [1:0] func_i,
  input  stat_t      stat_i,
  output cmd_t       cmd_o,
  output logic       busy_o,
  output logic       done_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.status = STAT_OK;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          unique case (func_i)
            FUNC_INSERT: state_d = S_INS_CHECK;
            FUNC_DELETE: state_d = S_DEL_CHECK;
            FUNC_QUERY: begin
              if (stat_i.root_empty) begin
                cmd_o.set_status = 1'b1;
                cmd_o.status     = STAT_EMPTY;
                state_d          = S_DONE;
              end else begin
                state_d = S_QUERY;
              end
            end
            default: state_d = S_DONE;
          endcase
        end
      end

      S_INS_CHECK: begin
        if (stat_i.count_full) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = STAT_POOL_FULL;
          state_d          = S_DONE;
        end else if (stat_i.go_off || stat_i.last) begin
          if (stat_i.pool_fail) begin
            cmd_o.set_status = 1'b1;
            cmd_o.status     = STAT_POOL_FULL;
            state_d          = S_DONE;
          end else begin
            cmd_o.init = 1'b1;
            state_d    = S_INS_UPD;
          end
        end else begin
          cmd_o.check_step = 1'b1;
        end
      end

      S_INS_UPD: begin
        cmd_o.ins_step = 1'b1;
        if (stat_i.last) begin
          state_d = S_DONE;
        end
      end

      S_DEL_CHECK: begin
        if (stat_i.absent) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = STAT_ABSENT;
          state_d          = S_DONE;
        end else if (stat_i.last) begin
          cmd_o.init = 1'b1;
          state_d    = S_DEL_UPD;
        end else begin
          cmd_o.check_step = 1'b1;
        end
      end

      S_DEL_UPD: begin
        cmd_o.del_step = 1'b1;
        if (stat_i.last) begin
          state_d = S_DONE;
        end
      end

      S_QUERY: begin
        cmd_o.query_step = 1'b1;
        if (stat_i.last) begin
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        state_d = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = (state_q == S_DONE);

endmodule

FILE: src/binary_trie_max_xor_core.sv
// Insert/delete: check walk over up to 31 levels, then a 31-level update walk, then the result state;
// query: one 31-level walk, then the result state; rejects end early.
// Throughput: one transaction at a time, next start taken the cycle after done_o;
// the rate is set by one node read per trie level from the single-read node RAM.
// Reset clears the root node and sets the free-node pointer to one; no clearing pass.
// The result is on the ports for the single done_o cycle; the receiver cannot stall.
module binary_trie_max_xor_core import bxt_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic [1:0]          func_i,
  input  logic [KEY_BITS-1:0] key_value_i,
  output logic                done_o,
  output logic [KEY_BITS-1:0] max_xor_o,
  output logic [1:0]          status_o
);

  cmd_t  cmd;
  stat_t stat;

  // Sequencer
  bxt_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .func_i  (func_i),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy_o),
    .done_o  (done_o)
  );

  // Trie walk and node store
  bxt_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .key_value_i (key_value_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .max_xor_o   (max_xor_o),
    .status_o    (status_o)
  );

endmodule

FILE: verif/testbench.sv
module testbench;
  import bxt_pkg::*;

  // func code 3 has no operation behind it
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam logic [KEY_BITS-1:0] KEY_MAX = '1;
  localparam int N_DIRECTED = 25;
  localparam int DRAIN_CYCLES = 70;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct packed {
    logic [1:0]          op;
    logic [KEY_BITS-1:0] key;
    logic                typed;
    logic [KEY_BITS-1:0] exp_xor;
    status_e             exp_status;
  } trie_vec_t;

  logic                clk_i;
  logic                rst_ni;
  logic                start_i;
  logic                busy_o;
  logic [1:0]          func_i;
  logic [KEY_BITS-1:0] key_value_i;
  logic                done_o;
  logic [KEY_BITS-1:0] max_xor_o;
  logic [1:0]          status_o;

  // Shadow trie and expected results
  node_t               trie_mem [NODE_POOL];
  int                  free_node;
  logic [KEY_BITS-1:0] exp_xor_q [$];
  logic [1:0]          exp_status_q [$];
  logic [KEY_BITS-1:0] live_keys [$];
  logic [KEY_BITS-1:0] key_pool [24];
  trie_vec_t           directed_vecs [N_DIRECTED];
  int                  mismatch_cnt;
  int                  pool_full_cnt;
  int                  cycle_cnt;

  binary_trie_max_xor_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .func_i      (func_i),
    .key_value_i (key_value_i),
    .done_o      (done_o),
    .max_xor_o   (max_xor_o),
    .status_o    (status_o)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Runaway guard
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("binary_trie_max_xor_core regression: fail");
      $finish;
    end
  end

  // Predict one operation on the shadow trie
  function automatic void predict_trie_op(input logic [1:0] op,
                                          input logic [KEY_BITS-1:0] key,
                                          output logic [KEY_BITS-1:0] best,
                                          output status_e st);
    int   cur;
    int   missing;
    int   nn;
    int   i;
    bit   off_tree;
    logic b;
    best = '0;
    st   = STAT_OK;
    cur  = 0;
    case (op)
      FUNC_INSERT: begin
        // check pass: count headroom, then node headroom
        missing  = 0;
        off_tree = 1'b0;
        for (i = KEY_BITS - 1; i >= 0; i--) begin
          b = key[i];
          if (off_tree) begin
            missing++;
          end else if (trie_mem[cur].count[b] == COUNT_MAX) begin
            st = STAT_POOL_FULL;
            break;
          end else if (trie_mem[cur].child[b] == '0) begin
            off_tree = 1'b1;
            missing++;
          end else begin
            cur = trie_mem[cur].child[b];
          end
        end
        if (st == STAT_OK && free_node + missing > NODE_POOL) st = STAT_POOL_FULL;
        if (st == STAT_OK) begin
          cur = 0;
          for (i = KEY_BITS - 1; i >= 0; i--) begin
            b = key[i];
            if (trie_mem[cur].child[b] == '0) begin
              nn = free_node;
              free_node++;
              trie_mem[nn] = '0;
              trie_mem[cur].child[b] = nn[NODE_AW-1:0];
            end
            trie_mem[cur].count[b] = trie_mem[cur].count[b] + 1'b1;
            cur = trie_mem[cur].child[b];
          end
        end
      end
      FUNC_DELETE: begin
        for (i = KEY_BITS - 1; i >= 0; i--) begin
          b = key[i];
          if (trie_mem[cur].child[b] == '0 || trie_mem[cur].count[b] == '0) begin
            st = STAT_ABSENT;
            break;
          end
          cur = trie_mem[cur].child[b];
        end
        if (st == STAT_OK) begin
          cur = 0;
          for (i = KEY_BITS - 1; i >= 0; i--) begin
            b = key[i];
            trie_mem[cur].count[b] = trie_mem[cur].count[b] - 1'b1;
            cur = trie_mem[cur].child[b];
          end
        end
      end
      FUNC_QUERY: begin
        if (trie_mem[0].count[0] == '0 && trie_mem[0].count[1] == '0) begin
          st = STAT_EMPTY;
        end else begin
          // greedy walk toward the opposite bit
          for (i = KEY_BITS - 1; i >= 0; i--) begin
            b = ~key[i];
            if (trie_mem[cur].child[b] != '0 && trie_mem[cur].count[b] != '0) begin
              best[i] = 1'b1;
              cur = trie_mem[cur].child[b];
            end else begin
              cur = trie_mem[cur].child[~b];
            end
          end
        end
      end
      default: ;
    endcase
  endfunction

  // Drive one transaction; called and returns at a falling edge
  task automatic issue(input logic [1:0] op, input logic [KEY_BITS-1:0] key,
                       input logic typed, input logic [KEY_BITS-1:0] t_xor,
                       input status_e t_status, output status_e st);
    logic [KEY_BITS-1:0] best;
    start_i     <= 1'b1;
    func_i      <= op;
    key_value_i <= key;
    while (busy_o) @(negedge clk_i);
    // accepted at the coming rising edge
    predict_trie_op(op, key, best, st);
    if (st == STAT_POOL_FULL) pool_full_cnt++;
    if (typed) begin
      exp_xor_q.push_back(t_xor);
      exp_status_q.push_back(t_status);
    end else begin
      exp_xor_q.push_back(best);
      exp_status_q.push_back(st);
    end
    @(negedge clk_i);
  endtask

  // Hold off until every outstanding result is back
  task automatic drain();
    start_i <= 1'b0;
    while (exp_xor_q.size() > 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // Random traffic; fill_pool biases toward fresh inserts until the pool runs dry
  task automatic run_phase(input int n_items, input int idle_pct, input bit fill_pool);
    int                  k;
    int                  r;
    int                  idx;
    int                  full_at_start;
    bit                  from_live;
    logic [1:0]          op;
    logic [KEY_BITS-1:0] key;
    status_e             st;
    full_at_start = pool_full_cnt;
    for (k = 0; fill_pool ? (pool_full_cnt - full_at_start < 20 && k < 600) : k < n_items;
         k++) begin
      if ($urandom_range(99) < idle_pct) begin
        start_i <= 1'b0;
        repeat ($urandom_range(1, 80)) @(negedge clk_i);
      end
      r = $urandom_range(99);
      from_live = 1'b0;
      idx = 0;
      if (r < (fill_pool ? 80 : 40)) begin
        op  = FUNC_INSERT;
        key = (!fill_pool && $urandom_range(99) < 60) ? key_pool[$urandom_range(23)]
                                                       : KEY_BITS'($urandom());
      end else if (r < (fill_pool ? 88 : 65)) begin
        op = FUNC_DELETE;
        r  = $urandom_range(99);
        if (r < 60 && live_keys.size() > 0) begin
          idx = $urandom_range(live_keys.size() - 1);
          key = live_keys[idx];
          from_live = 1'b1;
        end else if (r < 85) begin
          key = key_pool[$urandom_range(23)];
        end else begin
          key = KEY_BITS'($urandom());
        end
      end else if (r < 98) begin
        op  = FUNC_QUERY;
        key = ($urandom_range(1) == 1) ? key_pool[$urandom_range(23)]
                                       : KEY_BITS'($urandom());
      end else begin
        op  = FUNC_UNUSED;
        key = KEY_BITS'($urandom());
      end
      issue(op, key, 1'b0, '0, STAT_OK, st);
      // track stored keys so deletes mostly hit
      if (op == FUNC_INSERT && st == STAT_OK) live_keys.push_back(key);
      if (from_live && st == STAT_OK) live_keys.delete(idx);
    end
  endtask

  // Result checker
  always @(posedge clk_i) begin : check_results
    logic [KEY_BITS-1:0] e_xor;
    logic [1:0]          e_status;
    if (rst_ni && done_o) begin
      if (exp_xor_q.size() == 0) begin
        mismatch_cnt <= mismatch_cnt + 1;
        if (mismatch_cnt < 10)
          $display("unexpected result: max_xor %h status %0d", max_xor_o, status_o);
      end else begin
        e_xor    = exp_xor_q.pop_front();
        e_status = exp_status_q.pop_front();
        if (max_xor_o !== e_xor || status_o !== e_status) begin
          mismatch_cnt <= mismatch_cnt + 1;
          if (mismatch_cnt < 10)
            $display("mismatch: max_xor exp %h got %h, status exp %0d got %0d",
                     e_xor, max_xor_o, e_status, status_o);
        end
      end
    end
  end

  // Main sequence
  initial begin : main_seq
    int      i;
    int      j;
    status_e st;
    rst_ni        = 1'b0;
    start_i       = 1'b0;
    func_i        = FUNC_INSERT;
    key_value_i   = '0;
    mismatch_cnt  = 0;
    pool_full_cnt = 0;
    cycle_cnt     = 0;
    trie_mem[0]   = '0;
    free_node     = 1;

    // keys that share prefixes so the trie branches deep
    key_pool[0] = '0;
    key_pool[1] = KEY_MAX;
    key_pool[2] = 31'h4000_0000;
    key_pool[3] = 31'h3FFF_FFFF;
    for (j = 4; j < 12; j++) key_pool[j] = KEY_BITS'($urandom());
    for (j = 12; j < 24; j++)
      key_pool[j] = (key_pool[4 + j % 8] & ~31'hFF) | 31'($urandom_range(255));

    // op, key, typed, expected max_xor, expected status
    directed_vecs = '{
      '{FUNC_QUERY,  31'h0,          1'b1, 31'h0,   STAT_EMPTY},
      '{FUNC_DELETE, 31'h0,          1'b1, 31'h0,   STAT_ABSENT},
      '{FUNC_UNUSED, KEY_MAX,        1'b1, 31'h0,   STAT_OK},
      '{FUNC_INSERT, 31'h0,          1'b1, 31'h0,   STAT_OK},
      '{FUNC_QUERY,  KEY_MAX,        1'b1, KEY_MAX, STAT_OK},
      '{FUNC_QUERY,  31'h0,          1'b1, 31'h0,   STAT_OK},
      '{FUNC_INSERT, KEY_MAX,        1'b1, 31'h0,   STAT_OK},
      '{FUNC_QUERY,  31'h0,          1'b1, KEY_MAX, STAT_OK},
      '{FUNC_QUERY,  31'h2AAA_AAAA,  1'b0, 31'h0,   STAT_OK},
      '{FUNC_DELETE, 31'h0001_2345,  1'b1, 31'h0,   STAT_ABSENT},
      '{FUNC_DELETE, 31'h0,          1'b1, 31'h0,   STAT_OK},
      '{FUNC_DELETE, 31'h0,          1'b1, 31'h0,   STAT_ABSENT},
      '{FUNC_QUERY,  KEY_MAX,        1'b1, 31'h0,   STAT_OK},
      '{FUNC_INSERT, KEY_MAX,        1'b1, 31'h0,   STAT_OK},
      '{FUNC_DELETE, KEY_MAX,        1'b1, 31'h0,   STAT_OK},
      '{FUNC_QUERY,  31'h0,          1'b1, KEY_MAX, STAT_OK},
      '{FUNC_DELETE, KEY_MAX,        1'b1, 31'h0,   STAT_OK},
      // nodes still exist but every count is zero
      '{FUNC_QUERY,  31'h0000_1234,  1'b1, 31'h0,   STAT_EMPTY},
      '{FUNC_DELETE, KEY_MAX,        1'b1, 31'h0,   STAT_ABSENT},
      '{FUNC_INSERT, 31'h4000_0000,  1'b0, 31'h0,   STAT_OK},
      '{FUNC_INSERT, 31'h3FFF_FFFF,  1'b0, 31'h0,   STAT_OK},
      '{FUNC_QUERY,  31'h0,          1'b0, 31'h0,   STAT_OK},
      '{FUNC_QUERY,  KEY_MAX,        1'b0, 31'h0,   STAT_OK},
      '{FUNC_UNUSED, 31'h0,          1'b1, 31'h0,   STAT_OK},
      '{FUNC_QUERY,  31'h5555_5555,  1'b0, 31'h0,   STAT_OK}
    };

    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed table, back to back
    for (i = 0; i < N_DIRECTED; i++)
      issue(directed_vecs[i].op, directed_vecs[i].key, directed_vecs[i].typed,
            directed_vecs[i].exp_xor, directed_vecs[i].exp_status, st);

    // Random phases with varying sender idling
    run_phase(100, 0, 1'b0);
    run_phase(100, 45, 1'b0);
    drain();
    run_phase(100, 18, 1'b0);
    // drive the node pool to exhaustion and past it
    run_phase(0, 10, 1'b1);

    drain();
    if (mismatch_cnt == 0 && exp_xor_q.size() == 0) begin
      $display("binary_trie_max_xor_core regression: pass");
    end else begin
      $display("binary_trie_max_xor_core regression: fail");
    end
    $finish;
  end

endmodule
